FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Define ASSERT_OFF to drop
// every check from the build.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every rising edge outside reset
`define RV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
// condition must never be seen outside reset
`define RV_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);
`else
`define RV_ASSERT(label, clk, rst, prop, msg)
`define RV_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

FILE: rtl/rv64alu_pkg.sv
// ----------------------------------------------------------------------------
// rv64alu_pkg
// Widths, opcodes, status codes and helpers of the RV64 register ALU.
// ----------------------------------------------------------------------------
package rv64alu_pkg;

   localparam int XLEN       = 64;
   localparam int IMM_W      = 20;
   localparam int IDX_W      = 5;
   localparam int FUNC_W     = 5;
   localparam int SHAMT_W    = 6;
   localparam int REG_COUNT  = 32;
   localparam int REG_ADDR_W = $clog2(REG_COUNT);

   localparam logic [IDX_W-1:0] SYSCALL_REG  = IDX_W'(17);
   localparam logic [XLEN-1:0]  SYSCALL_EXIT = XLEN'(2);
   localparam logic [XLEN-1:0]  SYSCALL_NOP  = XLEN'(23);
   localparam int               LUI_SHIFT    = 12;
   localparam logic [XLEN-1:0]  PC_STEP      = XLEN'(4);

   localparam logic [IDX_W:0] REG_LIMIT = (IDX_W + 1)'(REG_COUNT);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LUI     = 5'd0,
      FUNC_ADD     = 5'd1,
      FUNC_ADDI    = 5'd2,
      FUNC_SUB     = 5'd3,
      FUNC_OR      = 5'd4,
      FUNC_ORI     = 5'd5,
      FUNC_AND     = 5'd6,
      FUNC_ANDI    = 5'd7,
      FUNC_XOR     = 5'd8,
      FUNC_XORI    = 5'd9,
      FUNC_SLL     = 5'd10,
      FUNC_SLLI    = 5'd11,
      FUNC_SRL     = 5'd12,
      FUNC_SRLI    = 5'd13,
      FUNC_SRA     = 5'd14,
      FUNC_SRAI    = 5'd15,
      FUNC_ECALL   = 5'd16,
      FUNC_ILLEGAL = 5'd17
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EXIT    = 2'd1,
      STATUS_UNKNOWN = 2'd2,
      STATUS_ILLEGAL = 2'd3
   } status_type;

   // execute unit result
   typedef struct packed {
      status_type      status;
      logic            alu_op;   // op produces a register value
      logic [XLEN-1:0] value;
   } alu_result_type;

   // register number names a real, writable register
   function automatic logic reg_live(input logic [IDX_W-1:0] idx);
      return (idx != '0) && ({1'b0, idx} < REG_LIMIT);
   endfunction

   // status codes that advance the PC
   function automatic logic status_advances(input status_type st);
      return (st == STATUS_OK) || (st == STATUS_EXIT);
   endfunction

endpackage

FILE: rtl/rv64alu_req_if.sv
// ----------------------------------------------------------------------------
// rv64alu_req_if
// Instruction channel: one decoded instruction per item.
// ----------------------------------------------------------------------------
interface rv64alu_req_if;
   import rv64alu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic [IDX_W-1:0]        src1_index;
   logic [IDX_W-1:0]        src2_index;
   logic [IDX_W-1:0]        dest_index;
   logic signed [IMM_W-1:0] immediate;

   modport source (
      output valid, func, src1_index, src2_index, dest_index, immediate,
      input  ready
   );

   modport sink (
      input  valid, func, src1_index, src2_index, dest_index, immediate,
      output ready
   );

endinterface

FILE: rtl/rv64alu_rsp_if.sv
// ----------------------------------------------------------------------------
// rv64alu_rsp_if
// Result channel: status, next PC and register write-back per item.
// ----------------------------------------------------------------------------
interface rv64alu_rsp_if;
   import rv64alu_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic [XLEN-1:0]        next_pc;
   logic                   write_enable;
   logic signed [XLEN-1:0] write_value;

   modport source (
      output valid, status, next_pc, write_enable, write_value,
      input  ready
   );

   modport sink (
      input  valid, status, next_pc, write_enable, write_value,
      output ready
   );

endinterface

FILE: rtl/rv64alu_ram.sv
// ----------------------------------------------------------------------------
// rv64alu_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rv64alu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/rv64alu_alu.sv
// ----------------------------------------------------------------------------
// rv64alu_alu
// Execute logic: operand select, add/sub, logic ops, shifts, ECALL decode.
// ----------------------------------------------------------------------------
module rv64alu_alu (
   input  logic [rv64alu_pkg::FUNC_W-1:0]       func,
   input  logic [rv64alu_pkg::XLEN-1:0]         op_a,
   input  logic [rv64alu_pkg::XLEN-1:0]         op_b,
   input  logic signed [rv64alu_pkg::IMM_W-1:0] immediate,
   input  logic [rv64alu_pkg::XLEN-1:0]         syscall_val,
   output rv64alu_pkg::alu_result_type          result
);
   import rv64alu_pkg::*;

   logic [XLEN-1:0]    imm_ext;
   logic [SHAMT_W-1:0] sh_reg;
   logic [SHAMT_W-1:0] sh_imm;

   assign imm_ext = {{(XLEN - IMM_W){immediate[IMM_W-1]}}, immediate};
   assign sh_reg  = op_b[SHAMT_W-1:0];
   assign sh_imm  = imm_ext[SHAMT_W-1:0];

   always_comb begin
      result.status = STATUS_OK;
      result.alu_op = 1'b1;
      result.value  = '0;
      unique case (func_type'(func))
         FUNC_LUI:  result.value = imm_ext << LUI_SHIFT;
         FUNC_ADD:  result.value = op_a + op_b;
         FUNC_ADDI: result.value = op_a + imm_ext;
         FUNC_SUB:  result.value = op_a - op_b;
         FUNC_OR:   result.value = op_a | op_b;
         FUNC_ORI:  result.value = op_a | imm_ext;
         FUNC_AND:  result.value = op_a & op_b;
         FUNC_ANDI: result.value = op_a & imm_ext;
         FUNC_XOR:  result.value = op_a ^ op_b;
         FUNC_XORI: result.value = op_a ^ imm_ext;
         FUNC_SLL:  result.value = op_a << sh_reg;
         FUNC_SLLI: result.value = op_a << sh_imm;
         FUNC_SRL:  result.value = op_a >> sh_reg;
         FUNC_SRLI: result.value = op_a >> sh_imm;
         FUNC_SRA:  result.value = $signed(op_a) >>> sh_reg;
         FUNC_SRAI: result.value = $signed(op_a) >>> sh_imm;
         FUNC_ECALL: begin
            result.alu_op = 1'b0;
            if (syscall_val == SYSCALL_NOP) begin
               result.status = STATUS_OK;
            end else if (syscall_val == SYSCALL_EXIT) begin
               result.status = STATUS_EXIT;
            end else begin
               result.status = STATUS_UNKNOWN;
            end
         end
         default: begin
            // explicit illegal and unused codes
            result.alu_op = 1'b0;
            result.status = STATUS_ILLEGAL;
         end
      endcase
   end

endmodule

FILE: rtl/rv64_register_alu_execute.sv
// ----------------------------------------------------------------------------
// rv64_register_alu_execute
// RV64 integer register/immediate ALU with register file and PC.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one decoded instruction per item (valid/ready); rsp_ch
//    returns one result per item: status, next_pc, write_enable and
//    write_value, in instruction order.
//  - csr_write_* sets the reset PC register; a reset loads the PC from it.
//    Reset itself clears that register, so a reset that stays high past
//    that clear starts the PC at zero. Write it only while the block is idle.
//  - An accepted item passes the execute stage, then the output register, to
//    rsp_ch. Throughput: one item per cycle while rsp_ch does not stall, set
//    by the single execute stage and the register file's registered read.
//  - The register file is a RAM with two registered read ports; the most
//    recent write is forwarded so back-to-back dependent items see it.
//    Per-entry valid bits make never-written registers read zero. x17 has
//    a shadow register so ECALL reads it without a third RAM port.
//  - rsp_ch stalls hold the output register; the execute stage keeps
//    accepting until it also holds an item, then req_ch.ready drops.
//  - Reset (synchronous, active high) empties both stages and clears the
//    valid bits so every register reads zero, with no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rv64_register_alu_execute (
   input  logic                          clock,
   input  logic                          reset,
   rv64alu_req_if.sink                   req_ch,
   rv64alu_rsp_if.source                 rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [rv64alu_pkg::XLEN-1:0]  csr_write_data
);
   import rv64alu_pkg::*;

   // config
   logic [XLEN-1:0] reset_pc_ff;

   // execute stage
   logic                    s1_vld_ff,  s1_vld_in;
   logic [FUNC_W-1:0]       s1_func_ff;
   logic [IDX_W-1:0]        s1_rs1_ff;
   logic [IDX_W-1:0]        s1_rs2_ff;
   logic [IDX_W-1:0]        s1_rd_ff;
   logic signed [IMM_W-1:0] s1_imm_ff;
   logic                    s1_live1_ff;  // source held a written value
   logic                    s1_live2_ff;

   // last register write, for forwarding
   logic                  fwd_vld_ff;
   logic [IDX_W-1:0]      fwd_addr_ff;
   logic [XLEN-1:0]       fwd_data_ff;

   // architectural state beside the RAM
   logic [REG_COUNT-1:0]  valid_ff;
   logic [XLEN-1:0]       x17_ff;
   logic [XLEN-1:0]       pc_ff, pc_in;

   // output register
   logic                  out_vld_ff, out_vld_in;
   status_type            out_status_ff;
   logic [XLEN-1:0]       out_pc_ff;
   logic                  out_we_ff;
   logic [XLEN-1:0]       out_val_ff;

   logic                  req_accept;
   logic                  s1_advance;
   logic [XLEN-1:0]       ram_a, ram_b;
   logic [XLEN-1:0]       op_a, op_b;
   logic [XLEN-1:0]       syscall_val;
   logic                  wr_en;
   alu_result_type        alu_res;

   localparam logic X17_PRESENT = reg_live(SYSCALL_REG);

   // ---------------- handshake ----------------
   assign s1_advance   = s1_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_vld_ff || s1_advance;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign s1_vld_in    = req_accept || (s1_vld_ff && !s1_advance);
   assign out_vld_in   = s1_advance || (out_vld_ff && !rsp_ch.ready);

   // ---------------- register file ----------------
   rv64alu_ram #(
      .WIDTH (XLEN),
      .DEPTH (REG_COUNT)
   ) u_regs (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (s1_rd_ff[REG_ADDR_W-1:0]),
      .wr_data   (alu_res.value),
      .rd_en     (req_accept),
      .rd_addr_a (req_ch.src1_index[REG_ADDR_W-1:0]),
      .rd_addr_b (req_ch.src2_index[REG_ADDR_W-1:0]),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   // forwarded write wins; a stale forward equals the RAM content anyway
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == s1_rs1_ff)) begin
         op_a = fwd_data_ff;
      end else if (s1_live1_ff) begin
         op_a = ram_a;
      end else begin
         op_a = '0;
      end
      if (fwd_vld_ff && (fwd_addr_ff == s1_rs2_ff)) begin
         op_b = fwd_data_ff;
      end else if (s1_live2_ff) begin
         op_b = ram_b;
      end else begin
         op_b = '0;
      end
   end

   assign syscall_val = X17_PRESENT ? x17_ff : '0;

   // ---------------- execute ----------------
   rv64alu_alu u_alu (
      .func        (s1_func_ff),
      .op_a        (op_a),
      .op_b        (op_b),
      .immediate   (s1_imm_ff),
      .syscall_val (syscall_val),
      .result      (alu_res)
   );

   // x0 and missing registers drop the write
   assign wr_en = s1_advance && alu_res.alu_op && reg_live(s1_rd_ff);

   assign pc_in = (s1_advance && status_advances(alu_res.status)) ?
                  (pc_ff + PC_STEP) : pc_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_pc_ff <= '0;
         pc_ff       <= reset_pc_ff;
         s1_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         fwd_vld_ff  <= 1'b0;
         valid_ff    <= '0;
         x17_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            reset_pc_ff <= csr_write_data;
         end
         pc_ff      <= pc_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
         if (s1_advance) begin
            fwd_vld_ff <= wr_en;
         end
         if (wr_en) begin
            valid_ff[s1_rd_ff[REG_ADDR_W-1:0]] <= 1'b1;
            if (s1_rd_ff == SYSCALL_REG) begin
               x17_ff <= alu_res.value;
            end
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff  <= req_ch.func;
         s1_rs1_ff   <= req_ch.src1_index;
         s1_rs2_ff   <= req_ch.src2_index;
         s1_rd_ff    <= req_ch.dest_index;
         s1_imm_ff   <= req_ch.immediate;
         s1_live1_ff <= reg_live(req_ch.src1_index) &&
                        valid_ff[req_ch.src1_index[REG_ADDR_W-1:0]];
         s1_live2_ff <= reg_live(req_ch.src2_index) &&
                        valid_ff[req_ch.src2_index[REG_ADDR_W-1:0]];
      end
      if (s1_advance) begin
         fwd_addr_ff   <= s1_rd_ff;
         fwd_data_ff   <= alu_res.value;
         out_status_ff <= alu_res.status;
         out_pc_ff     <= pc_in;
         out_we_ff     <= wr_en;
         out_val_ff    <= alu_res.value;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.status       = out_status_ff;
   assign rsp_ch.next_pc      = out_pc_ff;
   assign rsp_ch.write_enable = out_we_ff;
   assign rsp_ch.write_value  = out_val_ff;

   // ---------------- checks ----------------
   `RV_ASSERT(a_pc_step, clock, reset, s1_advance && status_advances(alu_res.status) |=> pc_ff == $past(pc_ff) + PC_STEP, "PC did not advance by one step")
   `RV_ASSERT(a_pc_hold, clock, reset, !s1_advance |=> pc_ff == $past(pc_ff), "PC moved without an item")
   `RV_ASSERT_NEVER(a_no_fault_write, clock, reset, wr_en && !status_advances(alu_res.status), "register written by a faulting item")
   `RV_ASSERT_NEVER(a_stage_overrun, clock, reset, req_accept && s1_vld_ff && !s1_advance, "item accepted over a held stage")
   `RV_ASSERT(a_valid_set, clock, reset, wr_en |=> valid_ff[$past(s1_rd_ff[REG_ADDR_W-1:0])], "written register not marked valid")

endmodule
